// ===== rtl/core/mcg_pkg.sv =====
// Shared types and constants for the midpoint circle generator.
`default_nettype none

package mcg_pkg;

    // Default coordinate width of the centre and octant registers.
    localparam int COORD_BITS_DEF = 13;

    // Depth of the descriptor queue between front and back end.
    localparam int QUEUE_DEPTH = 2;

    // Input word kind carried on the input tuser bit.
    typedef enum logic {
        CMD_START   = 1'b0,
        CMD_ADVANCE = 1'b1
    } mcg_cmd_t;

    // Per-set flags that travel with each descriptor.
    typedef struct packed {
        logic fill;
        logic done;
    } mcg_flags_t;

    // Last result index of a set, by mode.
    localparam logic [2:0] LAST_IDX_SPAN  = 3'd3;
    localparam logic [2:0] LAST_IDX_POINT = 3'd7;

endpackage

`default_nettype wire

// ===== rtl/core/mcg_front.sv =====
// Front end: accepts command words, steps the octant state and queues at most one set descriptor per word.
`default_nettype none

module mcg_front #(
    parameter int COORD_BITS = mcg_pkg::COORD_BITS_DEF,
    localparam int RADIUS_W = COORD_BITS - 2,
    localparam int DEC_W    = COORD_BITS + 3,
    localparam int DESC_W   = 4 * COORD_BITS + 2
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire mcg_pkg::mcg_cmd_t            in_cmd,
    input  wire logic signed [COORD_BITS-1:0] in_center_x,
    input  wire logic signed [COORD_BITS-1:0] in_center_y,
    input  wire logic [RADIUS_W-1:0]          in_radius,
    input  wire logic                         in_filled,
    output logic                              q_push,
    output logic [DESC_W-1:0]                 q_data,
    input  wire logic                         q_full
);
    import mcg_pkg::*;

    logic signed [COORD_BITS-1:0] cx_reg, cx_next;
    logic signed [COORD_BITS-1:0] cy_reg, cy_next;
    logic signed [COORD_BITS-1:0] x_reg, x_next;
    logic signed [COORD_BITS-1:0] y_reg, y_next;
    logic signed [DEC_W-1:0]      d_reg, d_next;
    logic                         fill_reg, fill_next;
    logic                         active_reg, active_next;
    logic                         accept;
    logic                         step_ok;
    logic signed [COORD_BITS-1:0] x_inc, y_dec;
    logic signed [DEC_W-1:0]      x_inc_e, y_dec_e, radius_e;
    mcg_flags_t                   flags;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign step_ok  = active_reg && !(y_reg < x_reg);

    assign x_inc    = x_reg + COORD_BITS'(1);
    assign y_dec    = y_reg - COORD_BITS'(1);
    assign x_inc_e  = DEC_W'(x_inc);
    assign y_dec_e  = DEC_W'(y_dec);
    assign radius_e = DEC_W'({1'b0, in_radius});

    always_comb begin
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        d_next      = d_reg;
        fill_next   = fill_reg;
        active_next = active_reg;
        q_push      = 1'b0;
        flags.fill  = fill_reg;
        flags.done  = 1'b0;
        if (accept) begin
            if (in_cmd == CMD_START) begin
                cx_next     = in_center_x;
                cy_next     = in_center_y;
                fill_next   = in_filled;
                x_next      = '0;
                y_next      = COORD_BITS'({1'b0, in_radius});
                d_next      = DEC_W'(3) - (radius_e <<< 1);
                active_next = 1'b1;
                q_push      = 1'b1;
                flags.fill  = in_filled;
            end else if (step_ok) begin
                x_next = x_inc;
                if (d_reg > 0) begin
                    y_next = y_dec;
                    d_next = d_reg + ((x_inc_e - y_dec_e) <<< 2) + DEC_W'(10);
                end else begin
                    d_next = d_reg + (x_inc_e <<< 2) + DEC_W'(6);
                end
                flags.done  = (y_next < x_next);
                active_next = !flags.done;
                q_push      = 1'b1;
            end else begin
                active_next = 1'b0;
            end
        end
    end

    assign q_data = {flags, y_next, x_next, cy_next, cx_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cx_reg     <= '0;
            cy_reg     <= '0;
            x_reg      <= '0;
            y_reg      <= '0;
            d_reg      <= '0;
            fill_reg   <= 1'b0;
            active_reg <= 1'b0;
        end else begin
            cx_reg     <= cx_next;
            cy_reg     <= cy_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
            d_reg      <= d_next;
            fill_reg   <= fill_next;
            active_reg <= active_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/mcg_queue.sv =====
// Short descriptor queue between front and back end.
`default_nettype none

module mcg_queue #(
    parameter int WIDTH = 8,
    localparam int DEPTH = mcg_pkg::QUEUE_DEPTH,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data,
    output logic                  not_empty
);
    import mcg_pkg::*;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/mcg_back.sv =====
// Back end: expands one set descriptor into points or spans, one word per unstalled cycle.
`default_nettype none

module mcg_back #(
    parameter int COORD_BITS = mcg_pkg::COORD_BITS_DEF,
    localparam int OUT_W  = COORD_BITS + 1,
    localparam int DESC_W = 4 * COORD_BITS + 2
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    q_valid,
    input  wire logic [DESC_W-1:0]       q_data,
    output logic                         q_pop,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic signed [OUT_W-1:0]      out_left,
    output logic signed [OUT_W-1:0]      out_right,
    output logic signed [OUT_W-1:0]      out_row,
    output logic                         out_last,
    output logic                         out_done
);
    import mcg_pkg::*;

    logic [DESC_W-1:0]            desc_reg;
    logic                         busy_reg, busy_next;
    logic [2:0]                   idx_reg, idx_next;
    logic                         valid_reg, valid_next;
    logic signed [OUT_W-1:0]      left_reg, right_reg, row_reg;
    logic                         last_reg, done_reg;

    logic signed [COORD_BITS-1:0] cx, cy, x, y;
    mcg_flags_t                   flags;
    logic signed [OUT_W-1:0]      cx_e, cy_e, x_e, y_e, a_e, b_e, abs_a;
    logic signed [OUT_W-1:0]      col, left_c, right_c, row_c;
    logic                         swap, row_neg, is_last, out_load;

    assign {flags, y, x, cy, cx} = desc_reg;

    assign cx_e = {cx[COORD_BITS-1], cx};
    assign cy_e = {cy[COORD_BITS-1], cy};
    assign x_e  = {x[COORD_BITS-1], x};
    assign y_e  = {y[COORD_BITS-1], y};

    // Spans walk rows cy+-y then cy+-x; points walk the eight mirrors in pairs.
    assign swap    = flags.fill ? idx_reg[1] : idx_reg[2];
    assign row_neg = flags.fill ? idx_reg[0] : idx_reg[1];
    assign a_e     = swap ? y_e : x_e;
    assign b_e     = swap ? x_e : y_e;
    assign abs_a   = a_e[OUT_W-1] ? -a_e : a_e;
    assign col     = idx_reg[0] ? (cx_e - a_e) : (cx_e + a_e);
    assign left_c  = flags.fill ? (cx_e - abs_a) : col;
    assign right_c = flags.fill ? (cx_e + abs_a) : col;
    assign row_c   = row_neg ? (cy_e - b_e) : (cy_e + b_e);
    assign is_last = (idx_reg == (flags.fill ? LAST_IDX_SPAN : LAST_IDX_POINT));

    assign out_load = busy_reg && (!valid_reg || out_ready);
    assign q_pop    = q_valid && (!busy_reg || (out_load && is_last));

    always_comb begin
        busy_next  = busy_reg;
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (out_ready) begin
            valid_next = 1'b0;
        end
        if (out_load) begin
            valid_next = 1'b1;
            idx_next   = idx_reg + 3'd1;
            if (is_last) begin
                busy_next = 1'b0;
            end
        end
        if (q_pop) begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            desc_reg <= q_data;
        end
        if (out_load) begin
            left_reg  <= left_c;
            right_reg <= right_c;
            row_reg   <= row_c;
            last_reg  <= is_last;
            done_reg  <= flags.done;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            busy_reg  <= busy_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_left  = left_reg;
    assign out_right = right_reg;
    assign out_row   = row_reg;
    assign out_last  = last_reg;
    assign out_done  = done_reg;

endmodule

`default_nettype wire

// ===== rtl/core/midpoint_circle_generator.sv =====
// The first word of a set passes through the queue, the descriptor register and the output register.
// One result word per cycle while m_axis_tready holds; a command yields eight words in outline
// mode and four in filled mode, on the single result channel that the back end drives.
// An advance command with no circle in progress produces no words.
// Reset (aresetn low, synchronous) clears the circle state, the queue and the output stage.
// After reset no circle is in progress and the centre, octant point and decision are zero.
`default_nettype none

module midpoint_circle_generator #(
    parameter int COORD_BITS = mcg_pkg::COORD_BITS_DEF,
    localparam int RADIUS_W  = COORD_BITS - 2,
    localparam int OUT_W     = COORD_BITS + 1,
    localparam int IN_BITS   = 3 * COORD_BITS - 1,
    localparam int IN_W      = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS  = 3 * OUT_W,
    localparam int OUT_W_BUS = ((OUT_BITS + 7) / 8) * 8,
    localparam int DESC_W    = 4 * COORD_BITS + 2
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // Command words.
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // tdata, lowest bit up: center_x, center_y, radius, filled, zero padding.
    input  wire logic [IN_W-1:0]      s_axis_tdata,
    // tuser: command (start or advance).
    input  wire logic                 s_axis_tuser,
    // Result words.
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // tdata, lowest bit up: span_left, span_right, span_row, zero padding.
    output logic [OUT_W_BUS-1:0]      m_axis_tdata,
    // tlast: last_of_set.
    output logic                      m_axis_tlast,
    // tuser: circle_done.
    output logic                      m_axis_tuser
);
    import mcg_pkg::*;

    // Unpacked command fields.
    logic signed [COORD_BITS-1:0] in_center_x, in_center_y;
    logic [RADIUS_W-1:0]          in_radius;
    logic                         in_filled;
    mcg_cmd_t                     in_cmd;

    // Descriptor queue between the front end and the back end.
    logic                         q_push, q_full, q_pop, q_valid;
    logic [DESC_W-1:0]            q_wdata, q_rdata;

    // Back end result fields.
    logic signed [OUT_W-1:0]      span_left, span_right, span_row;

    assign in_center_x = s_axis_tdata[COORD_BITS-1:0];
    assign in_center_y = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
    assign in_radius   = s_axis_tdata[2*COORD_BITS+RADIUS_W-1:2*COORD_BITS];
    assign in_filled   = s_axis_tdata[2*COORD_BITS+RADIUS_W];
    assign in_cmd      = mcg_cmd_t'(s_axis_tuser);

    // The front end owns the circle state: a start word reloads it and queues a descriptor
    // of the centre, octant point and fill and done flags; an advance word runs one midpoint
    // step, queuing one if a circle was in progress. It stalls only when the queue is full.
    mcg_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_cmd      (in_cmd),
        .in_center_x (in_center_x),
        .in_center_y (in_center_y),
        .in_radius   (in_radius),
        .in_filled   (in_filled),
        .q_push      (q_push),
        .q_data      (q_wdata),
        .q_full      (q_full)
    );

    mcg_queue #(
        .WIDTH (DESC_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .not_empty (q_valid)
    );

    // The back end walks each descriptor through its eight points or four spans, writing
    // one word per cycle into the output register while m_axis_tready allows, and fetches
    // the next one in the cycle that issues the last word of a set, so sets follow gap-free.
    mcg_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_data    (q_rdata),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_left  (span_left),
        .out_right (span_right),
        .out_row   (span_row),
        .out_last  (m_axis_tlast),
        .out_done  (m_axis_tuser)
    );

    assign m_axis_tdata = OUT_W_BUS'({span_row, span_right, span_left});

    // The queue is never written while full: the front end's ready follows the full flag.
    assert property (@(posedge aclk) disable iff (!aresetn) !(q_push && q_full))
        else $error("descriptor queue written while full");

    // The back end never fetches from an empty queue.
    assert property (@(posedge aclk) disable iff (!aresetn) !(q_pop && !q_valid))
        else $error("descriptor fetched from an empty queue");

    // An accepted advance word that finds the circle finished queues nothing, so a word
    // accepted right after a done-flagged descriptor was queued must not push again
    // unless it is a start.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (q_push && q_wdata[0 + 4*COORD_BITS])
            |=> !(q_push && s_axis_tvalid && s_axis_tready && (in_cmd == CMD_ADVANCE)))
        else $error("advance word stepped a finished circle");

endmodule

`default_nettype wire
